@@ hw/rtl/hrm_pkg.sv @@
// Shared types and constants for the hit run merger.
package hrm_pkg;

    // Field and position widths
    localparam int POS_BITS   = 32;
    localparam int FIELD_W    = 32;
    localparam int POS_W      = (POS_BITS < FIELD_W) ? POS_BITS : FIELD_W;
    localparam int NUM_FIELDS = 5;
    localparam int TDATA_W    = ((NUM_FIELDS * FIELD_W + 7) / 8) * 8;

    // Result queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [POS_W:0]     wpos_t;

    localparam pos_t POS_MAX = '1;

    // One hit as taken from the input channel
    typedef struct packed {
        field_t seq_x_index;
        field_t seq_y_index;
        pos_t   start_x;
        pos_t   start_y;
        pos_t   hit_length;
        logic   last_hit;
    } hit_t;

    // One merged group as sent on the result channel
    typedef struct packed {
        field_t group_seq_x;
        field_t group_seq_y;
        field_t group_start_x;
        field_t group_start_y;
        field_t group_length;
        logic   end_of_list;
    } result_t;

    // Results written into the queue in one cycle, first entry first
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

@@ hw/rtl/hrm_merge_unit.sv @@
// Input register, open group state and merge decision for one hit per cycle while the result queue has room.
module hrm_merge_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           hit_valid,
    output logic           hit_ready,
    input  hrm_pkg::hit_t  hit_in,
    input  logic           queue_room,
    output hrm_pkg::push_t push
);
    import hrm_pkg::*;

    logic  in_valid_reg, in_valid_next;
    hit_t  hit_reg;

    logic   open_reg, open_next;
    field_t open_seq_x_reg, open_seq_x_next;
    field_t open_seq_y_reg, open_seq_y_next;
    pos_t   open_start_x_reg, open_start_x_next;
    pos_t   open_start_y_reg, open_start_y_next;
    pos_t   open_length_reg, open_length_next;
    wpos_t  open_end_reg, open_end_next;
    wpos_t  open_sat_end_reg, open_sat_end_next;

    logic  advance;
    logic  joins;
    logic  closes;
    logic  widens;
    logic  saturates;
    wpos_t new_end;
    wpos_t span;
    result_t closed_group;
    result_t flushed_group;

    // Take a hit when the register is empty or drains this cycle
    assign advance   = in_valid_reg && queue_room;
    assign hit_ready = !in_valid_reg || advance;

    assign in_valid_next = hit_ready ? hit_valid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit_ready && hit_valid) begin
            hit_reg <= hit_in;
        end
    end

    // Join test against the exclusive end, one bit wider so it never wraps
    always_comb begin
        joins = open_reg
             && (hit_reg.seq_x_index == open_seq_x_reg)
             && (hit_reg.seq_y_index == open_seq_y_reg)
             && ({1'b0, hit_reg.start_x} < open_end_reg);
        closes    = open_reg && !joins;
        new_end   = {1'b0, hit_reg.start_x} + {1'b0, hit_reg.hit_length};
        widens    = joins && (new_end > open_end_reg);
        span      = new_end - {1'b0, open_start_x_reg};
        saturates = span[POS_W];
    end

    // Next group state: open on a new hit, widen on a joining hit, clear on last
    always_comb begin
        open_seq_x_next   = open_seq_x_reg;
        open_seq_y_next   = open_seq_y_reg;
        open_start_x_next = open_start_x_reg;
        open_start_y_next = open_start_y_reg;
        open_length_next  = open_length_reg;
        open_end_next     = open_end_reg;
        open_sat_end_next = open_sat_end_reg;
        if (!open_reg || closes) begin
            open_seq_x_next   = hit_reg.seq_x_index;
            open_seq_y_next   = hit_reg.seq_y_index;
            open_start_x_next = hit_reg.start_x;
            open_start_y_next = hit_reg.start_y;
            open_length_next  = hit_reg.hit_length;
            open_end_next     = new_end;
            open_sat_end_next = {1'b0, hit_reg.start_x} + {1'b0, POS_MAX};
        end else if (widens) begin
            open_length_next = saturates ? POS_MAX : span[POS_W-1:0];
            open_end_next    = saturates ? open_sat_end_reg : new_end;
        end
        open_next = advance ? !hit_reg.last_hit : open_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
        end else begin
            open_reg <= open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_seq_x_reg   <= '0;
            open_seq_y_reg   <= '0;
            open_start_x_reg <= '0;
            open_start_y_reg <= '0;
            open_length_reg  <= '0;
            open_end_reg     <= '0;
            open_sat_end_reg <= '0;
        end else if (advance) begin
            open_seq_x_reg   <= open_seq_x_next;
            open_seq_y_reg   <= open_seq_y_next;
            open_start_x_reg <= open_start_x_next;
            open_start_y_reg <= open_start_y_next;
            open_length_reg  <= open_length_next;
            open_end_reg     <= open_end_next;
            open_sat_end_reg <= open_sat_end_next;
        end
    end

    // Build the closed group and the flushed group
    always_comb begin
        closed_group.group_seq_x   = open_seq_x_reg;
        closed_group.group_seq_y   = open_seq_y_reg;
        closed_group.group_start_x = FIELD_W'(open_start_x_reg);
        closed_group.group_start_y = FIELD_W'(open_start_y_reg);
        closed_group.group_length  = FIELD_W'(open_length_reg);
        closed_group.end_of_list   = 1'b0;

        flushed_group.group_seq_x   = open_seq_x_next;
        flushed_group.group_seq_y   = open_seq_y_next;
        flushed_group.group_start_x = FIELD_W'(open_start_x_next);
        flushed_group.group_start_y = FIELD_W'(open_start_y_next);
        flushed_group.group_length  = FIELD_W'(open_length_next);
        flushed_group.end_of_list   = 1'b1;
    end

    // Hand zero, one or two results to the queue
    always_comb begin
        push.count  = 2'd0;
        push.first  = closes ? closed_group : flushed_group;
        push.second = flushed_group;
        if (advance) begin
            push.count = 2'({1'b0, closes} + {1'b0, hit_reg.last_hit});
        end
    end

    // The stored end always matches start plus length while a group is open
    assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> (open_end_reg == {1'b0, open_start_x_reg} + {1'b0, open_length_reg}))
        else $error("open group end out of step with its length");

    // A last hit leaves no group open
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && hit_reg.last_hit) |=> !open_reg)
        else $error("group still open after last hit");

    // Group state holds while no hit is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(open_reg) && $stable(open_length_reg)))
        else $error("group state moved without a hit");

endmodule

@@ hw/rtl/hrm_result_fifo.sv @@
// Small result queue that takes up to two groups a cycle and sends one while the output is ready.
module hrm_result_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  hrm_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output hrm_pkg::result_t out_data
);
    import hrm_pkg::*;

    result_t entries [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entries[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming groups in order
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entries[wr_ptr_reg + FIFO_AW'(1)] <= push.second;
        end
    end

    // Occupancy never exceeds the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    // No writes arrive unless there was room for two
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> room)
        else $error("result written without room");

    // Pointers stay in step with the occupancy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == FIFO_CW'(FIFO_DEPTH))
            |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

@@ hw/rtl/hit_run_merger_core.sv @@
// Top level of the hit run merger: stream ports, merge unit and result queue.
// Data path: input register, then merge decision, then result queue, then the master side.
// Throughput: one hit per cycle while each hit closes or flushes at most one group and
// m_tready is high; a hit that closes and flushes gives the result port two groups.
// The result port sends one group per cycle while m_tready is high; the input
// holds off while the four-entry result queue has room for fewer than two groups.
// Reset: synchronous, active low; clears the input register, the open group and the queue.
module hit_run_merger_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // seq_x_index, seq_y_index, start_x, start_y, hit_length (lowest first)
    input  logic [hrm_pkg::TDATA_W-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // group_seq_x, group_seq_y, group_start_x, group_start_y, group_length (lowest first)
    output logic [hrm_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import hrm_pkg::*;

    hit_t    hit_in;
    push_t   push;
    logic    queue_room;
    result_t out_data;

    // Unpack the incoming transaction
    always_comb begin
        hit_in.seq_x_index = s_tdata[0*FIELD_W +: FIELD_W];
        hit_in.seq_y_index = s_tdata[1*FIELD_W +: FIELD_W];
        hit_in.start_x     = s_tdata[2*FIELD_W +: POS_W];
        hit_in.start_y     = s_tdata[3*FIELD_W +: POS_W];
        hit_in.hit_length  = s_tdata[4*FIELD_W +: POS_W];
        hit_in.last_hit    = s_tlast;
    end

    hrm_merge_unit u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .hit_valid  (s_tvalid),
        .hit_ready  (s_tready),
        .hit_in     (hit_in),
        .queue_room (queue_room),
        .push       (push)
    );

    hrm_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (queue_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Pack the outgoing transaction
    always_comb begin
        m_tdata = '0;
        m_tdata[0*FIELD_W +: FIELD_W] = out_data.group_seq_x;
        m_tdata[1*FIELD_W +: FIELD_W] = out_data.group_seq_y;
        m_tdata[2*FIELD_W +: FIELD_W] = out_data.group_start_x;
        m_tdata[3*FIELD_W +: FIELD_W] = out_data.group_start_y;
        m_tdata[4*FIELD_W +: FIELD_W] = out_data.group_length;
        m_tlast = out_data.end_of_list;
    end

endmodule

@@ test/testbench.sv @@
// Testbench for hit_run_merger_core: random sorted hit lists, predicted groups, stream checks.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned TARGET_HITS = 400;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [hrm_pkg::TDATA_W-1:0] s_tdata = '0;
    logic                        s_tlast = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [hrm_pkg::TDATA_W-1:0] m_tdata;
    logic                        m_tlast;

    hrm_pkg::hit_t    pending_hits[$];
    hrm_pkg::result_t expected_groups[$];
    hrm_pkg::hit_t    hit_on_bus;
    logic             hit_taken = 1'b0;

    // Open group as the predictor sees it
    logic             grp_open;
    hrm_pkg::field_t  grp_seq_x;
    hrm_pkg::field_t  grp_seq_y;
    hrm_pkg::pos_t    grp_start_x;
    hrm_pkg::pos_t    grp_start_y;
    hrm_pkg::pos_t    grp_length;

    int unsigned hits_accepted = 0;
    int unsigned groups_checked = 0;
    int unsigned lists_closed = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned total_hits;
    logic        quiet_stretch;

    hit_run_merger_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // No idling on either side for a stretch of the run
    assign quiet_stretch = (hits_accepted >= 150) && (hits_accepted < 250);

    // Push the open group as an expected result
    function automatic void emit_group(logic eol);
        hrm_pkg::result_t g;
        g.group_seq_x   = grp_seq_x;
        g.group_seq_y   = grp_seq_y;
        g.group_start_x = grp_start_x;
        g.group_start_y = grp_start_y;
        g.group_length  = grp_length;
        g.end_of_list   = eol;
        expected_groups.push_back(g);
    endfunction

    function automatic void open_group(hrm_pkg::hit_t h);
        grp_open    = 1'b1;
        grp_seq_x   = h.seq_x_index;
        grp_seq_y   = h.seq_y_index;
        grp_start_x = h.start_x;
        grp_start_y = h.start_y;
        grp_length  = h.hit_length;
    endfunction

    // Take one hit into the open group; emit closed and flushed groups
    function automatic void merge_hit(hrm_pkg::hit_t h);
        hrm_pkg::wpos_t old_end;
        hrm_pkg::wpos_t new_end;
        hrm_pkg::wpos_t span;
        if (!grp_open) begin
            open_group(h);
        end else begin
            old_end = {1'b0, grp_start_x} + {1'b0, grp_length};
            if (h.seq_x_index == grp_seq_x && h.seq_y_index == grp_seq_y &&
                {1'b0, h.start_x} < old_end) begin
                new_end = {1'b0, h.start_x} + {1'b0, h.hit_length};
                if (new_end > old_end) begin
                    span = new_end - {1'b0, grp_start_x};
                    // saturate the widened length
                    grp_length = (span > {1'b0, hrm_pkg::POS_MAX}) ?
                                 hrm_pkg::POS_MAX : span[hrm_pkg::POS_W-1:0];
                end
            end else begin
                emit_group(1'b0);
                open_group(h);
            end
        end
        if (h.last_hit) begin
            emit_group(1'b1);
            grp_open = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    task automatic queue_hit(input hrm_pkg::field_t sx, input hrm_pkg::field_t sy,
                             input hrm_pkg::pos_t x, input hrm_pkg::pos_t y,
                             input hrm_pkg::pos_t len, input logic last);
        hrm_pkg::hit_t h;
        h.seq_x_index = sx;
        h.seq_y_index = sy;
        h.start_x     = x;
        h.start_y     = y;
        h.hit_length  = len;
        h.last_hit    = last;
        pending_hits.push_back(h);
    endtask

    // One sorted list of hits; near_top places it at the end of the position range
    task automatic queue_run(input bit near_top, input bit flush);
        int unsigned     n_hits;
        int unsigned     k;
        hrm_pkg::field_t sx;
        hrm_pkg::field_t sy;
        hrm_pkg::pos_t   x;
        hrm_pkg::pos_t   len;
        n_hits = $urandom_range(1, 10);
        sx = $urandom_range(0, 3);
        sy = $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) begin
            sx = $urandom;
            sy = $urandom;
        end
        x = near_top ? (32'hFFFF_FFFF - $urandom_range(0, 200)) : $urandom_range(0, 1000);
        len = $urandom_range(1, 20);
        for (k = 0; k < n_hits; k++) begin
            if (k > 0) begin
                // mostly advance within the pair, sometimes move to the next pair
                if ($urandom_range(0, 4) == 0) begin
                    sy = sy + 1;
                    x = near_top ? (32'hFFFF_FFFF - $urandom_range(0, 200)) :
                                   $urandom_range(0, 50);
                end else begin
                    x = x + $urandom_range(0, 23);
                end
                if ($urandom_range(0, near_top ? 2 : 15) == 0)
                    len = $urandom;
                else
                    len = $urandom_range(1, 20);
            end
            queue_hit(sx, sy, x, $urandom, len, flush && (k == n_hits - 1));
        end
    endtask

    // Drive the input channel; advance to the next hit once one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || hit_taken) begin
            if (pending_hits.size() != 0 &&
                (quiet_stretch || $urandom_range(0, 99) >= 10)) begin
                hit_on_bus = pending_hits.pop_front();
                s_tdata  <= {hit_on_bus.hit_length, hit_on_bus.start_y, hit_on_bus.start_x,
                             hit_on_bus.seq_y_index, hit_on_bus.seq_x_index};
                s_tlast  <= hit_on_bus.last_hit;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_tready <= quiet_stretch || ($urandom_range(0, 99) >= 10);
    end

    // Predict on each accepted hit, check each accepted group
    always @(posedge aclk) begin
        hrm_pkg::result_t want;
        if (!aresetn) begin
            hit_taken      <= 1'b0;
            grp_open       = 1'b0;
            grp_seq_x      = '0;
            grp_seq_y      = '0;
            grp_start_x    = '0;
            grp_start_y    = '0;
            grp_length     = '0;
        end else begin
            hit_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                merge_hit(hit_on_bus);
                hits_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_groups.size() == 0) begin
                    $error("group received with none expected: tdata %0h tlast %0b",
                           m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_groups.pop_front();
                    check_field("group_seq_x", want.group_seq_x,
                                m_tdata[0 +: hrm_pkg::FIELD_W]);
                    check_field("group_seq_y", want.group_seq_y,
                                m_tdata[hrm_pkg::FIELD_W +: hrm_pkg::FIELD_W]);
                    check_field("group_start_x", want.group_start_x,
                                m_tdata[2*hrm_pkg::FIELD_W +: hrm_pkg::FIELD_W]);
                    check_field("group_start_y", want.group_start_y,
                                m_tdata[3*hrm_pkg::FIELD_W +: hrm_pkg::FIELD_W]);
                    check_field("group_length", want.group_length,
                                m_tdata[4*hrm_pkg::FIELD_W +: hrm_pkg::FIELD_W]);
                    check_field("end_of_list", {31'b0, want.end_of_list}, {31'b0, m_tlast});
                    groups_checked++;
                    if (m_tlast)
                        lists_closed++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d groups still expected",
                   cycle_count, expected_groups.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // Directed: extremes, single-hit list, same start join, contained hit
        queue_hit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 1'b1);
        queue_hit(32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 1'b0);
        queue_hit(32'd0, 32'd0, 32'd0, 32'd100, 32'd5, 1'b0);
        queue_hit(32'd0, 32'd0, 32'd4, 32'd7, 32'd1, 1'b0);
        // start at the exclusive end closes; zero-length groups
        queue_hit(32'd0, 32'd0, 32'd5, 32'd5, 32'd0, 1'b0);
        queue_hit(32'd0, 32'd0, 32'd5, 32'd9, 32'd3, 1'b0);
        queue_hit(32'd0, 32'd1, 32'd6, 32'd6, 32'd2, 1'b0);
        queue_hit(32'd0, 32'd1, 32'd7, 32'd0, 32'd0, 1'b0);
        // only the first-axis index differs
        queue_hit(32'd1, 32'd1, 32'd7, 32'd0, 32'd4, 1'b0);
        // length saturation near the top of the position range
        queue_hit(32'd2, 32'd2, 32'hFFFF_FFF0, 32'd0, 32'd16, 1'b0);
        queue_hit(32'd2, 32'd2, 32'hFFFF_FFF8, 32'd3, 32'hFFFF_FFFF, 1'b0);
        queue_hit(32'd2, 32'd2, 32'hFFFF_FFFF, 32'd1, 32'd1, 1'b1);
        // a hit that both closes a group and flushes its own
        queue_hit(32'd3, 32'd3, 32'd10, 32'd20, 32'd4, 1'b0);
        queue_hit(32'd4, 32'd4, 32'd0, 32'd0, 32'd1, 1'b1);
        // diagonal is ignored; joining hit carries the flush
        queue_hit(32'd5, 32'd3, 32'd0, 32'd50, 32'd8, 1'b0);
        queue_hit(32'd5, 32'd3, 32'd7, 32'hFFFF_FFFF, 32'd10, 1'b1);

        // Random: mostly sorted lists, some noise and unflushed lists
        while (pending_hits.size() < TARGET_HITS) begin
            case ($urandom_range(0, 9))
                0: queue_hit($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(0, 3) == 0);
                1: queue_run(1'b0, 1'b0);
                2: queue_run(1'b1, 1'b1);
                default: queue_run(1'b0, 1'b1);
            endcase
        end
        queue_hit($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 20), 1'b1);
        total_hits = pending_hits.size();

        // Hold reset, then release on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for all hits, then all groups, then let the pipeline settle
        do @(posedge aclk); while (pending_hits.size() != 0 || s_tvalid);
        while (expected_groups.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Merged %0d of %0d hits into %0d checked groups, %0d of them ending a list",
                 hits_accepted, total_hits, groups_checked, lists_closed);
        if (mismatch_count == 0 && expected_groups.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/hrm_pkg.sv
hw/rtl/hrm_merge_unit.sv
hw/rtl/hrm_result_fifo.sv
hw/rtl/hit_run_merger_core.sv
test/testbench.sv
